FILE: rtl/rvdec_pkg.sv
// Shared types, opcodes and decode result structure of the RV32I instruction decoder.
package rvdec_pkg;

	localparam int unsigned WordWidth = 32;
	localparam int unsigned RegIdxWidth = 5;

	typedef logic [6:0] opcode_t;

	localparam opcode_t OP_LUI    = 7'b0110111;
	localparam opcode_t OP_AUIPC  = 7'b0010111;
	localparam opcode_t OP_JAL    = 7'b1101111;
	localparam opcode_t OP_JALR   = 7'b1100111;
	localparam opcode_t OP_BRANCH = 7'b1100011;
	localparam opcode_t OP_LOAD   = 7'b0000011;
	localparam opcode_t OP_STORE  = 7'b0100011;
	localparam opcode_t OP_ALUI   = 7'b0010011;
	localparam opcode_t OP_ALU    = 7'b0110011;
	localparam opcode_t OP_ENV    = 7'b1110011;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [WordWidth-1:0] IMM_R_FMT = 32'hFFFF_FFFF;
	localparam logic [WordWidth-1:0] IMM_X_FMT = 32'hFFFF_FFFE;

	typedef enum logic [2:0] {
		FMT_R = 3'd0,
		FMT_I = 3'd1,
		FMT_S = 3'd2,
		FMT_B = 3'd3,
		FMT_U = 3'd4,
		FMT_J = 3'd5,
		FMT_X = 3'd6
	} fmt_t;

	typedef enum logic [5:0] {
		KIND_UNSUP = 6'd0,
		KIND_LUI   = 6'd1,
		KIND_AUIPC = 6'd2,
		KIND_JAL   = 6'd3,
		KIND_JALR  = 6'd4,
		KIND_BEQ   = 6'd5,
		KIND_BNE   = 6'd6,
		KIND_BLT   = 6'd7,
		KIND_BGE   = 6'd8,
		KIND_BLTU  = 6'd9,
		KIND_BGEU  = 6'd10,
		KIND_LB    = 6'd11,
		KIND_LH    = 6'd12,
		KIND_LW    = 6'd13,
		KIND_LBU   = 6'd14,
		KIND_LHU   = 6'd15,
		KIND_SB    = 6'd16,
		KIND_SH    = 6'd17,
		KIND_SW    = 6'd18,
		KIND_ADDI  = 6'd19,
		KIND_SLTI  = 6'd20,
		KIND_SLTIU = 6'd21,
		KIND_XORI  = 6'd22,
		KIND_ORI   = 6'd23,
		KIND_ANDI  = 6'd24,
		KIND_SLLI  = 6'd25,
		KIND_SRLI  = 6'd26,
		KIND_SRAI  = 6'd27,
		KIND_ADD   = 6'd28,
		KIND_SUB   = 6'd29,
		KIND_SLL   = 6'd30,
		KIND_SLT   = 6'd31,
		KIND_SLTU  = 6'd32,
		KIND_XOR   = 6'd33,
		KIND_SRL   = 6'd34,
		KIND_SRA   = 6'd35,
		KIND_OR    = 6'd36,
		KIND_AND   = 6'd37,
		KIND_ECALL = 6'd38
	} kind_t;

	typedef struct packed {
		kind_t                        kind;
		fmt_t                         fmt;
		logic signed [WordWidth-1:0]  imm;
		logic [RegIdxWidth-1:0]       rd;
		logic [RegIdxWidth-1:0]       rs1;
		logic [RegIdxWidth-1:0]       rs2;
	} dec_res_t;

endpackage

FILE: rtl/rvdec_decode.sv
// Combinational decode of one RV32I instruction word into kind, format, immediate and registers.
module rvdec_decode (
	input  logic [rvdec_pkg::WordWidth-1:0] word,
	output rvdec_pkg::dec_res_t             res
);
	import rvdec_pkg::*;

	opcode_t    opcode;
	logic [2:0] f3;
	logic [6:0] f7;
	kind_t      kind;
	fmt_t       fmt;
	logic [WordWidth-1:0] imm;

	assign opcode = word[6:0];
	assign f3     = word[14:12];
	assign f7     = word[31:25];

	always_comb begin
		case (opcode)
			OP_BRANCH: fmt = FMT_B;
			OP_LUI, OP_AUIPC: fmt = FMT_U;
			OP_JAL: fmt = FMT_J;
			OP_JALR, OP_LOAD, OP_ALUI, OP_ENV: fmt = FMT_I;
			OP_ALU: fmt = FMT_R;
			OP_STORE: fmt = FMT_S;
			default: fmt = FMT_X;
		endcase
	end

	always_comb begin
		kind = KIND_UNSUP;
		case (opcode)
			OP_LUI: kind = KIND_LUI;
			OP_AUIPC: kind = KIND_AUIPC;
			OP_JAL: kind = KIND_JAL;
			OP_JALR: kind = KIND_JALR;
			OP_BRANCH: begin
				case (f3)
					3'd0: kind = KIND_BEQ;
					3'd1: kind = KIND_BNE;
					3'd4: kind = KIND_BLT;
					3'd5: kind = KIND_BGE;
					3'd6: kind = KIND_BLTU;
					3'd7: kind = KIND_BGEU;
					default: kind = KIND_UNSUP;
				endcase
			end
			OP_LOAD: begin
				case (f3)
					3'd0: kind = KIND_LB;
					3'd1: kind = KIND_LH;
					3'd2: kind = KIND_LW;
					3'd4: kind = KIND_LBU;
					3'd5: kind = KIND_LHU;
					default: kind = KIND_UNSUP;
				endcase
			end
			OP_STORE: begin
				case (f3)
					3'd0: kind = KIND_SB;
					3'd1: kind = KIND_SH;
					3'd2: kind = KIND_SW;
					default: kind = KIND_UNSUP;
				endcase
			end
			OP_ALUI: begin
				case (f3)
					3'd0: kind = KIND_ADDI;
					3'd1: kind = KIND_SLLI;
					3'd2: kind = KIND_SLTI;
					3'd3: kind = KIND_SLTIU;
					3'd4: kind = KIND_XORI;
					3'd5: begin
						if (f7 == F7_BASE) begin
							kind = KIND_SRLI;
						end else if (f7 == F7_ALT) begin
							kind = KIND_SRAI;
						end
					end
					3'd6: kind = KIND_ORI;
					3'd7: kind = KIND_ANDI;
					default: kind = KIND_UNSUP;
				endcase
			end
			OP_ALU: begin
				case (f3)
					3'd0: begin
						if (f7 == F7_BASE) begin
							kind = KIND_ADD;
						end else if (f7 == F7_ALT) begin
							kind = KIND_SUB;
						end
					end
					3'd1: kind = KIND_SLL;
					3'd2: kind = KIND_SLT;
					3'd3: kind = KIND_SLTU;
					3'd4: kind = KIND_XOR;
					3'd5: begin
						if (f7 == F7_BASE) begin
							kind = KIND_SRL;
						end else if (f7 == F7_ALT) begin
							kind = KIND_SRA;
						end
					end
					3'd6: kind = KIND_OR;
					3'd7: kind = KIND_AND;
					default: kind = KIND_UNSUP;
				endcase
			end
			OP_ENV: begin
				if (word[31:20] == 12'd0) begin
					kind = KIND_ECALL;
				end
			end
			default: kind = KIND_UNSUP;
		endcase
	end

	always_comb begin
		case (fmt)
			FMT_I: imm = {{21{word[31]}}, word[30:20]};
			FMT_S: imm = {{21{word[31]}}, word[30:25], word[11:7]};
			FMT_B: imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
			FMT_U: imm = {word[31:12], 12'd0};
			FMT_J: imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
			FMT_R: imm = IMM_R_FMT;
			default: imm = IMM_X_FMT;
		endcase
	end

	always_comb begin
		res.kind = kind;
		res.fmt  = fmt;
		res.imm  = $signed(imm);
		res.rd   = word[11:7];
		res.rs1  = word[19:15];
		res.rs2  = word[24:20];
	end

endmodule

FILE: rtl/rv32i_instruction_decoder_unit.sv
// Top level of the RV32I instruction decoder: input register, decode logic and result register.
//
// The decoder accepts one instruction word per clock cycle while in_stall is low and returns one
// result per word. The word is captured in an input register, decoded by a single pass of
// combinational logic, and the result is held in an output register; each register advances
// whenever the stage after it is empty or moving, so a stall on the output holds both stages
// and is passed back to the input through in_stall.
module rv32i_instruction_decoder_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [rvdec_pkg::WordWidth-1:0]        instruction_word,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [5:0]                             instruction_kind,
	output logic [2:0]                             format_kind,
	output logic signed [rvdec_pkg::WordWidth-1:0] immediate_value,
	output logic [rvdec_pkg::RegIdxWidth-1:0]      dest_register,
	output logic [rvdec_pkg::RegIdxWidth-1:0]      source_register_one,
	output logic [rvdec_pkg::RegIdxWidth-1:0]      source_register_two
);
	import rvdec_pkg::*;

	logic                 valid_s1;
	logic [WordWidth-1:0] word_s1;
	logic                 valid_s2;
	dec_res_t             res_s2;
	dec_res_t             dec_res;
	logic                 adv_s2;
	logic                 adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= instruction_word;
		end
	end

	rvdec_decode u_decode (
		.word (word_s1),
		.res  (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign out_valid           = valid_s2;
	assign instruction_kind    = res_s2.kind;
	assign format_kind         = res_s2.fmt;
	assign immediate_value     = res_s2.imm;
	assign dest_register       = res_s2.rd;
	assign source_register_one = res_s2.rs1;
	assign source_register_two = res_s2.rs2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("Input stalled while a pipeline stage was free.");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("Accepted transfer did not reach the input register.");

	a_unknown_is_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && format_kind == FMT_X) |->
		(instruction_kind == KIND_UNSUP && immediate_value == $signed(IMM_X_FMT)))
		else $error("Unknown format with a supported kind or wrong immediate.");

	a_r_fmt_imm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && format_kind == FMT_R) |-> immediate_value == $signed(IMM_R_FMT))
		else $error("R format result without the all-ones immediate.");

	a_ecall_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && instruction_kind == KIND_ECALL) |->
		(format_kind == FMT_I && immediate_value == '0 && source_register_two == '0))
		else $error("ECALL decoded with nonzero function field.");

endmodule

FILE: sim/rv32i_instruction_decoder_unit_tb.sv
// Self-checking testbench of the RV32I instruction decoder: directed table, random words, stalls.
`timescale 1ns / 100ps

module rv32i_instruction_decoder_unit_tb;

	import rvdec_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 9;
	localparam int NUM_ROWS = 26;
	localparam int RANDOM_WORDS = 1850 - NUM_ROWS;
	localparam int LONG_HOLD = 60;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_OPS = 11;
	localparam opcode_t OP_MISC_MEM = 7'b0001111;
	localparam logic [2:0] F3_ADD_SUB = 3'b000;
	localparam logic [2:0] F3_SHIFT_RIGHT = 3'b101;

	typedef struct packed {
		logic [31:0] word;
		logic        has_golden;
		kind_t       kind;
		fmt_t        fmt;
		logic [31:0] imm;
	} stim_row_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_stall;
	logic [WordWidth-1:0]                   instruction_word;
	logic                                   out_valid;
	logic                                   out_stall;
	logic [5:0]                             instruction_kind;
	logic [2:0]                             format_kind;
	logic signed [WordWidth-1:0]            immediate_value;
	logic [RegIdxWidth-1:0]                 dest_register;
	logic [RegIdxWidth-1:0]                 source_register_one;
	logic [RegIdxWidth-1:0]                 source_register_two;

	dec_res_t pending_decodes [$];
	int       fail_count = 0;
	int       cycle_count = 0;
	int       send_idle_pct;
	int       recv_idle_pct;
	bit       hold_req;

	kind_t branch_by_f3 [8] = '{KIND_BEQ, KIND_BNE, KIND_UNSUP, KIND_UNSUP,
		KIND_BLT, KIND_BGE, KIND_BLTU, KIND_BGEU};
	kind_t load_by_f3 [8] = '{KIND_LB, KIND_LH, KIND_LW, KIND_UNSUP,
		KIND_LBU, KIND_LHU, KIND_UNSUP, KIND_UNSUP};
	kind_t store_by_f3 [8] = '{KIND_SB, KIND_SH, KIND_SW, KIND_UNSUP,
		KIND_UNSUP, KIND_UNSUP, KIND_UNSUP, KIND_UNSUP};
	kind_t alui_by_f3 [8] = '{KIND_ADDI, KIND_SLLI, KIND_SLTI, KIND_SLTIU,
		KIND_XORI, KIND_UNSUP, KIND_ORI, KIND_ANDI};
	kind_t alu_by_f3 [8] = '{KIND_UNSUP, KIND_SLL, KIND_SLT, KIND_SLTU,
		KIND_XOR, KIND_UNSUP, KIND_OR, KIND_AND};
	opcode_t known_ops [NUM_OPS] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
		OP_LOAD, OP_STORE, OP_ALUI, OP_ALU, OP_ENV, OP_MISC_MEM};

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{32'h0000_0000, 1'b1, KIND_UNSUP, FMT_X, IMM_X_FMT},
		'{32'hFFFF_FFFF, 1'b1, KIND_UNSUP, FMT_X, IMM_X_FMT},
		'{32'h0000_0073, 1'b1, KIND_ECALL, FMT_I, 32'h0000_0000},
		'{32'h0000_0F73, 1'b1, KIND_ECALL, FMT_I, 32'h0000_0000},
		'{32'h0010_0073, 1'b1, KIND_UNSUP, FMT_I, 32'h0000_0001},
		'{32'h0000_000F, 1'b1, KIND_UNSUP, FMT_X, IMM_X_FMT},
		'{32'h0100_000F, 1'b1, KIND_UNSUP, FMT_X, IMM_X_FMT},
		'{32'h0000_0033, 1'b1, KIND_ADD, FMT_R, IMM_R_FMT},
		'{32'h4000_0033, 1'b1, KIND_SUB, FMT_R, IMM_R_FMT},
		'{32'hFE00_0033, 1'b1, KIND_UNSUP, FMT_R, IMM_R_FMT},
		'{32'h0200_5033, 1'b1, KIND_UNSUP, FMT_R, IMM_R_FMT},
		'{32'hFFFF_F037, 1'b1, KIND_LUI, FMT_U, 32'hFFFF_F000},
		'{32'h0000_0017, 1'b1, KIND_AUIPC, FMT_U, 32'h0000_0000},
		'{32'h8000_006F, 1'b1, KIND_JAL, FMT_J, 32'hFFF0_0000},
		'{32'h7FFF_F06F, 1'b1, KIND_JAL, FMT_J, 32'h000F_FFFE},
		'{32'hFFF0_7067, 1'b1, KIND_JALR, FMT_I, 32'hFFFF_FFFF},
		'{32'h8000_0063, 1'b1, KIND_BEQ, FMT_B, 32'hFFFF_F000},
		'{32'h7FFF_FFE3, 1'b1, KIND_BGEU, FMT_B, 32'h0000_0FFE},
		'{32'h0000_2063, 1'b1, KIND_UNSUP, FMT_B, 32'h0000_0000},
		'{32'h0000_3003, 1'b1, KIND_UNSUP, FMT_I, 32'h0000_0000},
		'{32'h8000_2003, 1'b1, KIND_LW, FMT_I, 32'hFFFF_F800},
		'{32'h0000_4023, 1'b1, KIND_UNSUP, FMT_S, 32'h0000_0000},
		'{32'hFE00_2FA3, 1'b1, KIND_SW, FMT_S, 32'hFFFF_FFFF},
		'{32'hFE00_1013, 1'b1, KIND_SLLI, FMT_I, 32'hFFFF_FFE0},
		'{32'h4000_5013, 1'b1, KIND_SRAI, FMT_I, 32'h0000_0400},
		'{32'hA5A5_A5EF, 1'b0, KIND_UNSUP, FMT_X, 32'h0000_0000}
	};

	rv32i_instruction_decoder_unit u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.instruction_word    (instruction_word),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.instruction_kind    (instruction_kind),
		.format_kind         (format_kind),
		.immediate_value     (immediate_value),
		.dest_register       (dest_register),
		.source_register_one (source_register_one),
		.source_register_two (source_register_two)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic dec_res_t decode_word(input logic [31:0] w);
		dec_res_t   r;
		logic [2:0] f3;
		logic [6:0] f7;
		f3 = w[14:12];
		f7 = w[31:25];
		r.rd = w[11:7];
		r.rs1 = w[19:15];
		r.rs2 = w[24:20];
		r.kind = KIND_UNSUP;
		r.fmt = FMT_X;
		case (opcode_t'(w[6:0]))
			OP_LUI: begin
				r.fmt = FMT_U;
				r.kind = KIND_LUI;
			end
			OP_AUIPC: begin
				r.fmt = FMT_U;
				r.kind = KIND_AUIPC;
			end
			OP_JAL: begin
				r.fmt = FMT_J;
				r.kind = KIND_JAL;
			end
			OP_JALR: begin
				r.fmt = FMT_I;
				r.kind = KIND_JALR;
			end
			OP_BRANCH: begin
				r.fmt = FMT_B;
				r.kind = branch_by_f3[f3];
			end
			OP_LOAD: begin
				r.fmt = FMT_I;
				r.kind = load_by_f3[f3];
			end
			OP_STORE: begin
				r.fmt = FMT_S;
				r.kind = store_by_f3[f3];
			end
			OP_ALUI: begin
				r.fmt = FMT_I;
				r.kind = alui_by_f3[f3];
				if (f3 == F3_SHIFT_RIGHT) begin
					r.kind = (f7 == F7_BASE) ? KIND_SRLI :
						(f7 == F7_ALT) ? KIND_SRAI : KIND_UNSUP;
				end
			end
			OP_ALU: begin
				r.fmt = FMT_R;
				r.kind = alu_by_f3[f3];
				if (f3 == F3_ADD_SUB) begin
					r.kind = (f7 == F7_BASE) ? KIND_ADD :
						(f7 == F7_ALT) ? KIND_SUB : KIND_UNSUP;
				end else if (f3 == F3_SHIFT_RIGHT) begin
					r.kind = (f7 == F7_BASE) ? KIND_SRL :
						(f7 == F7_ALT) ? KIND_SRA : KIND_UNSUP;
				end
			end
			OP_ENV: begin
				r.fmt = FMT_I;
				r.kind = (w[31:20] == 12'd0) ? KIND_ECALL : KIND_UNSUP;
			end
			default: begin
				r.fmt = FMT_X;
			end
		endcase
		case (r.fmt)
			FMT_I: r.imm = {{21{w[31]}}, w[30:20]};
			FMT_S: r.imm = {{21{w[31]}}, w[30:25], w[11:7]};
			FMT_B: r.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
			FMT_U: r.imm = {w[31:12], 12'd0};
			FMT_J: r.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			FMT_R: r.imm = IMM_R_FMT;
			default: r.imm = IMM_X_FMT;
		endcase
		return r;
	endfunction

	// Most words carry a known opcode with biased funct7 and funct12; the rest are raw noise.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		opcode_t     op;
		w = $urandom;
		if ($urandom_range(0, 99) < 15) begin
			return w;
		end
		op = known_ops[$urandom_range(0, NUM_OPS - 1)];
		w[6:0] = op;
		if (op == OP_ALU || op == OP_ALUI) begin
			case ($urandom_range(0, 2))
				0: w[31:25] = F7_BASE;
				1: w[31:25] = F7_ALT;
				default: ;
			endcase
		end
		if (op == OP_ENV && $urandom_range(0, 1) == 0) begin
			w[31:20] = 12'd0;
		end
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w, input dec_res_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		do @(posedge clk); while (in_stall);
		pending_decodes.push_back(want);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		dec_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_decodes.size() == 0) begin
				$error("result transfer with no decode pending");
				fail_count++;
			end else begin
				want = pending_decodes.pop_front();
				check_field("instruction_kind", 32'(want.kind), 32'(instruction_kind));
				check_field("format_kind", 32'(want.fmt), 32'(format_kind));
				check_field("immediate_value", want.imm, immediate_value);
				check_field("dest_register", 32'(want.rd), 32'(dest_register));
				check_field("source_register_one", 32'(want.rs1), 32'(source_register_one));
				check_field("source_register_two", 32'(want.rs2), 32'(source_register_two));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : result_side
		bit hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	initial begin : word_side
		dec_res_t    want;
		logic [31:0] w;
		send_idle_pct = 14;
		recv_idle_pct = 50;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		instruction_word <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			want = decode_word(directed_rows[i].word);
			if (directed_rows[i].has_golden) begin
				want.kind = directed_rows[i].kind;
				want.fmt = directed_rows[i].fmt;
				want.imm = directed_rows[i].imm;
			end
			send_word(directed_rows[i].word, want);
		end
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 14;
			end
			if (i == 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = 1'b1;
			end
			w = random_word();
			send_word(w, decode_word(w));
		end
		in_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_decodes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
